@@ design/lis_pkg.sv @@
package lis_pkg;

  // Width of the reported run length field.
  localparam int unsigned RUN_LEN_W = 11;

  // Width of the sequence values.
  localparam int unsigned VALUE_W = 32;

  // Sequencer states of the search controller.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_LOOK,
    ST_UPD
  } ctrl_state_t;

  // One finished result, handed from the controller to the output register.
  typedef struct packed {
    logic [RUN_LEN_W-1:0] run_length;
    logic                 done_res;
    logic                 full_res;
  } lis_res_t;

endpackage

@@ design/lis_ram.sv @@
module lis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/lis_ctrl.sv @@
module lis_ctrl #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  in_value,
  input  logic                         in_last,
  output logic [$clog2(MAX_LEN)-1:0]   ram_raddr,
  input  logic [31:0]                  ram_rdata,
  output logic                         ram_we,
  output logic [$clog2(MAX_LEN)-1:0]   ram_waddr,
  output logic [31:0]                  ram_wdata,
  output logic                         res_valid,
  input  logic                         res_ready,
  output lis_pkg::lis_res_t            res
);

  import lis_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

  ctrl_state_t state_r, state_nxt;

  logic [CW-1:0]      lo_r, hi_r, mid_r, count_r;
  logic [VALUE_W-1:0] v_r;
  logic               last_r;

  logic [CW-1:0]      srch_lo, srch_hi, srch_mid;
  logic               tail_less;
  logic               append, drop;
  logic [CW-1:0]      count_upd;
  logic [CW+RUN_LEN_W-1:0] count_ext;

  // Search window for this cycle: a fresh window on entry, otherwise the
  // window narrowed by the tail that the last read returned.
  assign tail_less = $signed(ram_rdata) < $signed(v_r);

  always_comb begin
    if (state_r == ST_LOOK) begin
      srch_lo = tail_less ? mid_r + CW'(1) : lo_r;
      srch_hi = tail_less ? hi_r : mid_r;
    end else begin
      srch_lo = '0;
      srch_hi = count_r;
    end
    srch_mid = srch_lo + ((srch_hi - srch_lo) >> 1);
  end

  // The search ends at lo; when it equals the count the value extends the
  // longest run, and that is dropped once the store is full.
  assign append    = (lo_r == count_r);
  assign drop      = append && (count_r == MAX_CNT);
  assign count_upd = (append && !drop) ? count_r + CW'(1) : count_r;
  assign count_ext = {{RUN_LEN_W{1'b0}}, count_upd};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START, ST_LOOK: begin
        state_nxt = (srch_lo < srch_hi) ? ST_LOOK : ST_UPD;
      end
      ST_UPD: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    ram_raddr      = srch_mid[AW-1:0];
    ram_we         = (state_r == ST_UPD) && res_ready && !drop;
    ram_waddr      = lo_r[AW-1:0];
    ram_wdata      = v_r;
    res_valid      = (state_r == ST_UPD);
    res.run_length = count_ext[RUN_LEN_W-1:0];
    res.done_res   = last_r;
    res.full_res   = drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_UPD) && res_ready) begin
        count_r <= last_r ? '0 : count_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      v_r    <= in_value;
      last_r <= in_last;
    end
    if ((state_r == ST_START) || (state_r == ST_LOOK)) begin
      lo_r  <= srch_lo;
      hi_r  <= srch_hi;
      mid_r <= srch_mid;
    end
  end

endmodule

@@ design/longest_increasing_subsequence_top.sv @@
// Each word is accepted, opens the search, probes the tail memory once per
// search step (at most ceil(log2(count + 1)) probes, 11 for 1024 tails)
// through the single read port, and is written back once the output
// register can take its result. A new word is accepted only when the last
// one is through, and the result may then wait in the output register.
// Reset (rst_n low, synchronous) empties the tail store; memory is not cleared.
module longest_increasing_subsequence_top #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value (signed)
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] run_length, [15:11] zero
  output logic        out_tlast,
  output logic        out_tuser   // [0] full_res
);

  import lis_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);

  logic [AW-1:0]      ram_raddr, ram_waddr;
  logic [VALUE_W-1:0] ram_rdata, ram_wdata;
  logic               ram_we;

  logic     res_valid, res_ready;
  lis_res_t res;

  // Output register: the controller may hand over a new result whenever the
  // register is empty or is being emptied in this cycle.
  logic     out_valid_r;
  lis_res_t out_res_r;

  // The tail memory holds the smallest tail of each run length. Entries at or
  // above the current count are never read, so it needs no clearing.
  lis_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_LEN)
  ) u_tail_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The controller runs the binary search with one signed compare per probe.
  lis_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata),
    .in_last   (in_tlast),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - RUN_LEN_W){1'b0}}, out_res_r.run_length};
  assign out_tlast  = out_res_r.done_res;
  assign out_tuser  = out_res_r.full_res;

endmodule

@@ dv/lis_checker.sv @@
// Watches both stream channels of the LIS block, keeps its own copy of the
// tail store and compares every result word against the oldest prediction.
module lis_checker #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          seqs_closed,
  output int          full_seen,
  output int          peak_len
);
  timeunit 1ns;
  timeprecision 1ps;

  import lis_pkg::*;

  logic signed [VALUE_W-1:0] tail_mem [MAX_LEN];
  int unsigned               tail_cnt;
  lis_res_t                  length_q [$];

  // Patience step: find the first tail not below the value, replace it or
  // append, and report the length of the longest strict run so far.
  function automatic lis_res_t next_length(input logic signed [VALUE_W-1:0] v,
                                           input logic l);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lis_res_t    r;
    lo = 0;
    hi = tail_cnt;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (tail_mem[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    r.full_res = 1'b0;
    if (lo < tail_cnt) begin
      tail_mem[lo] = v;
    end else if (tail_cnt < MAX_LEN) begin
      tail_mem[tail_cnt] = v;
      tail_cnt++;
    end else begin
      r.full_res = 1'b1;
    end
    r.run_length = tail_cnt[RUN_LEN_W-1:0];
    r.done_res   = l;
    if (l) tail_cnt = 0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch on result %0d: got 0x%0h, want 0x%0h",
             $time, what, results_seen, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    seqs_closed  = 0;
    full_seen    = 0;
    peak_len     = 0;
    tail_cnt     = 0;
  end

  always @(posedge clk) begin : watch
    lis_res_t want;
    if (!rst_n) begin
      tail_cnt = 0;
      length_q.delete();
    end else begin
      // Input first: a word's own result can never leave on its accept edge.
      if (in_tvalid && in_tready)
        length_q = {length_q, next_length($signed(in_tdata), in_tlast)};
      if (out_tvalid && out_tready) begin
        if (length_q.size() == 0) begin
          report_mismatch("unexpected word", {16'd0, out_tdata}, 32'd0);
        end else begin
          want = length_q.pop_front();
          if (out_tdata !== {{(16 - RUN_LEN_W){1'b0}}, want.run_length})
            report_mismatch("run_length", {16'd0, out_tdata},
                            {21'd0, want.run_length});
          if (out_tlast !== want.done_res)
            report_mismatch("done_res", {31'd0, out_tlast}, {31'd0, want.done_res});
          if (out_tuser !== want.full_res)
            report_mismatch("full_res", {31'd0, out_tuser}, {31'd0, want.full_res});
          if (want.done_res) seqs_closed++;
          if (want.full_res) full_seen++;
          if (int'(want.run_length) > peak_len) peak_len = int'(want.run_length);
        end
        results_seen++;
      end
    end
    pending = length_q.size();
  end

endmodule

@@ dv/tb.sv @@
// Top of the LIS testbench: clock, reset, stimulus on the input stream,
// back-pressure on the result stream, a watchdog and the final verdict.
// All prediction and comparison lives in lis_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN = 1024;

  // Cycles the receiver holds off in the long stall phase.
  localparam int LONG_HOLD = 300;
  // Cycles without any accepted word before the run is declared hung.
  // The longest legitimate quiet stretch is the long hold, so the limit
  // lies above that.
  localparam int WATCHDOG_LIMIT = 3000;
  // Extra cycles after the last result, longer than the block's latency.
  localparam int TAIL_WAIT = 40;
  // Number of random words to aim for, not counting the store-filling run.
  localparam int RANDOM_WORDS = 480;
  // Near the end of the run the last words go through with no idling.
  localparam int QUIET_WORDS = 130;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value (signed)
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [10:0] run_length, [15:11] zero
  logic        out_tlast;
  logic        out_tuser;  // [0] full_res

  int fail_count;
  int pending;
  int results_seen;
  int seqs_closed;
  int full_seen;
  int peak_len;

  int   words_sent;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic hold_req;
  int   quiet_cycles;

  longest_increasing_subsequence_top #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  lis_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen),
    .seqs_closed (seqs_closed),
    .full_seen   (full_seen),
    .peak_len    (peak_len)
  );

  initial clk = 1'b0;
  always #5ns clk = ~clk;

  // The watchdog counts cycles in which neither channel moves a word. A
  // healthy block never goes quiet for long while words are still owed.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("tb failed");
        $finish;
      end
    end
  end

  // Receiver side. Every falling edge it decides tready for the next cycle.
  // Random bursts of back-pressure come at a rate set by the stimulus phase;
  // a hold request turns into one long stall, counted here, during which
  // the sender keeps offering words.
  initial begin : rx_side
    int gap_left;
    gap_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        gap_left = LONG_HOLD;
      end else if (gap_left == 0 && rx_idle_pct > 0 &&
                   $urandom_range(0, 99) < rx_idle_pct) begin
        gap_left = $urandom_range(1, 18);
      end
      if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one word, called on a falling edge and returning on a falling
  // edge. An optional idle burst comes first; valid stays high from one
  // word to the next when there is no burst, so it is never dropped and
  // raised within the same step.
  task automatic send_word(input logic [31:0] v, input logic l);
    int gap;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One random sequence closed by tlast. Four in ten shapes climb, so the tail
  // store grows and the search goes several levels deep; the others give
  // repeats, pure noise, falling runs and the extreme values.
  task automatic send_random_sequence();
    int          len;
    int          shape;
    logic [31:0] v;
    logic [31:0] prev;
    len   = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
    shape = $urandom_range(0, 9);
    prev  = $urandom;
    v     = prev;
    for (int k = 0; k < len; k++) begin
      case (shape)
        0, 1, 2, 3: begin
          // Mostly climbing, with an occasional dip that replaces a tail.
          if ($urandom_range(0, 4) == 0) v = prev - $urandom_range(0, 5000);
          else v = prev + $urandom_range(0, 3000);
        end
        4, 5: v = $urandom_range(0, 15) - 8;
        6, 7: v = $urandom;
        8:    v = prev - $urandom_range(0, 1000);
        default: begin
          case ($urandom_range(0, 5))
            0:       v = 32'h8000_0000;
            1:       v = 32'h8000_0001;
            2:       v = 32'h7fff_fffe;
            3:       v = 32'h7fff_ffff;
            4:       v = 32'h0000_0000;
            default: v = 32'hffff_ffff;
          endcase
        end
      endcase
      prev = v;
      send_word(v, k == len - 1);
    end
  endtask

  // One long strictly rising sequence that fills all MAX_LEN tails, then
  // asks for more appends so the store-full flag must come up. A few words
  // on the way slip under an earlier tail and only replace it. After the
  // store is full a replacing word must not raise the flag, and the closing
  // word is the largest value, which again finds the store full.
  task automatic send_filling_sequence();
    logic [31:0] v;
    for (int i = 0; i < MAX_LEN + 5; i++) begin
      v = 32'h8000_0000 + i * 4096 + $urandom_range(1, 4095);
      send_word(v, 1'b0);
      if (i % 100 == 50) send_word(32'h8000_0000 + (i - 5) * 4096, 1'b0);
    end
    send_word(32'h8000_0000 + 10 * 4096, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);
  endtask

  initial begin : stimulus
    int rand_start;
    int filled;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    hold_req    = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    words_sent  = 0;
    filled      = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words. Light idling on both sides from the start.
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    // Zero, then a smaller value that replaces the only tail, both extremes,
    // and an equal value that must not extend a strict run.
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'd6, 1'b1);
    // Sequences of a single word, at both extremes.
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7fff_ffff, 1'b1);
    // A strictly falling run keeps the length at one throughout.
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'd100, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(-32'sd100, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    // A rising run across zero, and alternating bit patterns.
    send_word(-32'sd3, 1'b0);
    send_word(-32'sd2, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'd1, 1'b1);
    send_word(32'haaaa_aaaa, 1'b0);
    send_word(32'h5555_5555, 1'b1);

    // Sender pause: nothing more is offered until every result is back.
    wait_for_results();

    // Long receiver stall with the sender pushing back to back, so the
    // block fills up and has to drop in_tready.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    for (int k = 0; k < 24; k++)
      send_word(32'h1000_0000 + k * 64 + $urandom_range(0, 63), k == 23);

    // Random sequences. Idling rates change per sequence, including
    // stretches with none; the final stretch runs without any idling.
    rand_start = words_sent;
    while (words_sent - rand_start < RANDOM_WORDS) begin
      if (words_sent - rand_start > RANDOM_WORDS - QUIET_WORDS) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       tx_idle_pct = 0;
          1:       tx_idle_pct = 5;
          2:       tx_idle_pct = 15;
          default: tx_idle_pct = 30;
        endcase
        case ($urandom_range(0, 3))
          0:       rx_idle_pct = 0;
          1:       rx_idle_pct = 5;
          2:       rx_idle_pct = 15;
          default: rx_idle_pct = 30;
        endcase
      end
      if (!filled && words_sent - rand_start >= 200) begin
        filled = 1;
        send_filling_sequence();
        rand_start += MAX_LEN + 17;
      end else begin
        send_random_sequence();
      end
    end

    wait_for_results();
    repeat (TAIL_WAIT) @(negedge clk);

    $display("Sent %0d words in %0d sequences and checked %0d results.",
             words_sent, seqs_closed, results_seen);
    $display("Longest run reported: %0d, store-full results: %0d, mismatches: %0d.",
             peak_len, full_seen, fail_count);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ longest_increasing_subsequence_top.f @@
design/lis_pkg.sv
design/lis_ram.sv
design/lis_ctrl.sv
design/longest_increasing_subsequence_top.sv
dv/lis_checker.sv
dv/tb.sv
